// ===== rtl/core/lbc_pkg.sv =====
package lbc_pkg;

  // Item commands
  typedef enum logic [2:0] {
    ACT_ON     = 3'd0,
    ACT_OFF    = 3'd1,
    ACT_TOGGLE = 3'd2,
    ACT_PERIOD = 3'd3,
    ACT_HZ_CNT = 3'd4,
    ACT_TICK   = 3'd5
  } action_e;

  // Drive actions reported with each result
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_ON     = 2'd1,
    OP_OFF    = 2'd2,
    OP_TOGGLE = 2'd3
  } drive_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  localparam int unsigned CmpDigits = 16;  // 2-bit digits over 32 bits
  localparam int unsigned DivBits   = 9;   // quotient bits of 500 / hz

  localparam logic [15:0] HalfPeriodDefault = 16'd500;
  localparam logic [8:0]  HzDividend        = 9'd500;   // 1000 / (2 * hz) == 500 / hz
  localparam logic [15:0] HzDivMax          = 16'd500;  // above this the quotient is 0
  localparam logic [15:0] CountSatLimit     = 16'd32767;
  localparam logic [15:0] TogglesMax        = 16'hFFFF;

endpackage

// ===== rtl/core/lbc_elapsed.sv =====
// Digit-serial check of (now - last) mod 2^32 >= half_period, 2 bits a cycle.
module lbc_elapsed (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] now_i,
  input  logic [31:0] last_i,
  input  logic [15:0] half_period_i,
  output logic        busy_o,
  output logic        due_o
);

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] now_q, now_d;
  logic [31:0] last_q, last_d;
  logic [15:0] hp_q, hp_d;
  logic        br_diff_q, br_diff_d;
  logic        br_cmp_q, br_cmp_d;
  logic [2:0]  diff_dig;
  logic [2:0]  cmp_dig;

  // elapsed digit, then elapsed minus half-period digit
  assign diff_dig = {1'b0, now_q[1:0]} - {1'b0, last_q[1:0]} - {2'b00, br_diff_q};
  assign cmp_dig  = {1'b0, diff_dig[1:0]} - {1'b0, hp_q[1:0]} - {2'b00, br_cmp_q};

  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    now_d     = now_q;
    last_d    = last_q;
    hp_d      = hp_q;
    br_diff_d = br_diff_q;
    br_cmp_d  = br_cmp_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      now_d     = now_i;
      last_d    = last_i;
      hp_d      = half_period_i;
      br_diff_d = 1'b0;
      br_cmp_d  = 1'b0;
    end else if (busy_q) begin
      now_d     = {2'b00, now_q[31:2]};
      last_d    = {2'b00, last_q[31:2]};
      hp_d      = {2'b00, hp_q[15:2]};
      br_diff_d = diff_dig[2];
      br_cmp_d  = cmp_dig[2];
      cnt_d     = cnt_q + 4'd1;
      if (cnt_q == 4'(lbc_pkg::CmpDigits - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      br_diff_q <= 1'b0;
      br_cmp_q  <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      br_diff_q <= br_diff_d;
      br_cmp_q  <= br_cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    last_q <= last_d;
    hp_q   <= hp_d;
  end

  assign busy_o = busy_q;
  assign due_o  = ~br_cmp_q;

endmodule

// ===== rtl/core/lbc_div.sv =====
// Bit-serial restoring division 500 / divisor, one quotient bit a cycle.
module lbc_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [8:0] divisor_i,
  output logic       busy_o,
  output logic [8:0] quotient_o
);

  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [8:0] dvd_q, dvd_d;
  logic [8:0] dvs_q, dvs_d;
  logic [8:0] rem_q, rem_d;
  logic [8:0] quo_q, quo_d;
  logic [9:0] trial;
  logic [9:0] trial_sub;
  logic       fits;

  assign trial     = {rem_q, dvd_q[8]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = lbc_pkg::HzDividend;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[7:0], 1'b0};
      rem_d = fits ? trial_sub[8:0] : trial[8:0];
      quo_d = {quo_q[7:0], fits};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(lbc_pkg::DivBits - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/led_blink_controller.sv =====
// Channel   | Dir | Group   | Transfer carries
// ----------+-----+---------+----------------------------------------------
// command   | in  | s_axis  | one command or tick item (96-bit tdata)
// result    | out | m_axis  | one drive action plus status (48-bit tdata)
//
// A new command is taken only once the previous one has completed. Unless the
// output stalls, the elapsed-time compare sets when a command completes: it
// walks the 32-bit timestamps 2 bits a cycle, while the 500/hz divider runs
// beside it and ends sooner. Reset clears all blink state to off, half-period 500.
// A stalled result waits in the output register while the next command is
// taken; that command's completion holds until the output register is free.
module led_blink_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[2:0], target_led[10:3], period_in[26:11], freq_in[42:27],
  // blink_count[58:43], stamp_ms[90:59], zero fill[95:91]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_op[1:0], drive_led[9:2], led_level[10], blinking[11],
  // freq_status[27:12], blinks_left[43:28], zero fill[47:44]
  output logic [47:0] m_axis_tdata
);

  lbc_pkg::state_e state_q, state_d;

  // Held item fields
  logic [2:0]  act_q;
  logic [7:0]  led_q;
  logic [15:0] period_q;
  logic [15:0] hz_q;
  logic [15:0] count_q;
  logic [31:0] now_q;

  // Blink state
  logic        blink_q, blink_d;
  logic        counted_q, counted_d;
  logic        level_q, level_d;
  logic [15:0] freq_q, freq_d;
  logic [15:0] hp_q, hp_d;
  logic [15:0] tl_q, tl_d;
  logic [31:0] last_q, last_d;

  // Output register
  logic        ov_q, ov_d;
  logic [47:0] out_q;

  logic        in_xfer;
  logic        finish;
  logic        cmp_busy, cmp_due;
  logic        div_busy;
  logic [8:0]  div_quo;
  logic [15:0] hp_hz;
  logic [15:0] tl_dec;
  logic [16:0] blinks_sum;
  logic [1:0]  op;
  logic [7:0]  dled;

  assign s_axis_tready = (state_q == lbc_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign finish        = (state_q == lbc_pkg::ST_BUSY) && !cmp_busy && !div_busy &&
                         (!ov_q || m_axis_tready);

  // Capture the item; the serial units load from the bus in the same cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q    <= s_axis_tdata[2:0];
      led_q    <= s_axis_tdata[10:3];
      period_q <= s_axis_tdata[26:11];
      hz_q     <= s_axis_tdata[42:27];
      count_q  <= s_axis_tdata[58:43];
      now_q    <= s_axis_tdata[90:59];
    end
  end

  lbc_elapsed u_elapsed (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_xfer),
    .now_i         (s_axis_tdata[90:59]),
    .last_i        (last_q),
    .half_period_i (hp_q),
    .busy_o        (cmp_busy),
    .due_o         (cmp_due)
  );

  lbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .divisor_i  (s_axis_tdata[35:27]),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Half-period from hz: default at 0, floor of 1 past 500 Hz
  always_comb begin
    if (hz_q == '0) begin
      hp_hz = lbc_pkg::HalfPeriodDefault;
    end else if (hz_q > lbc_pkg::HzDivMax) begin
      hp_hz = 16'd1;
    end else begin
      hp_hz = {7'd0, div_quo};
    end
  end

  assign tl_dec = (tl_q != '0) ? tl_q - 16'd1 : tl_q;

  // Apply the held item to the blink state
  always_comb begin
    blink_d   = blink_q;
    counted_d = counted_q;
    level_d   = level_q;
    freq_d    = freq_q;
    hp_d      = hp_q;
    tl_d      = tl_q;
    last_d    = last_q;
    op        = lbc_pkg::OP_NONE;
    dled      = '0;
    case (act_q)
      lbc_pkg::ACT_ON, lbc_pkg::ACT_OFF, lbc_pkg::ACT_TOGGLE: begin
        blink_d   = 1'b0;
        counted_d = 1'b0;
        freq_d    = '0;
        tl_d      = '0;
        dled      = led_q;
        if (act_q == lbc_pkg::ACT_ON) begin
          level_d = 1'b1;
          op      = lbc_pkg::OP_ON;
        end else if (act_q == lbc_pkg::ACT_OFF) begin
          level_d = 1'b0;
          op      = lbc_pkg::OP_OFF;
        end else begin
          level_d = ~level_q;
          op      = lbc_pkg::OP_TOGGLE;
        end
      end
      lbc_pkg::ACT_PERIOD: begin
        blink_d   = 1'b1;
        counted_d = 1'b0;
        freq_d    = '0;
        hp_d      = (period_q == '0) ? lbc_pkg::HalfPeriodDefault : period_q;
        last_d    = now_q;
      end
      lbc_pkg::ACT_HZ_CNT: begin
        blink_d   = 1'b1;
        counted_d = (count_q != '0);
        level_d   = 1'b0;
        freq_d    = hz_q;
        hp_d      = hp_hz;
        tl_d      = (count_q > lbc_pkg::CountSatLimit) ? lbc_pkg::TogglesMax
                                                       : {count_q[14:0], 1'b0};
        last_d    = now_q;
        op        = lbc_pkg::OP_OFF;
        dled      = led_q;
      end
      lbc_pkg::ACT_TICK: begin
        if (blink_q && cmp_due) begin
          last_d  = now_q;
          level_d = ~level_q;
          op      = lbc_pkg::OP_TOGGLE;
          if (counted_q) begin
            tl_d = tl_dec;
            // counted run used up: stop and leave the LED off
            if (tl_dec == '0) begin
              blink_d   = 1'b0;
              counted_d = 1'b0;
              freq_d    = '0;
              level_d   = 1'b0;
              op        = lbc_pkg::OP_OFF;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign blinks_sum = {1'b0, tl_d} + 17'd1;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    if (m_axis_tready) begin
      ov_d = 1'b0;
    end
    case (state_q)
      lbc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = lbc_pkg::ST_BUSY;
        end
      end
      lbc_pkg::ST_BUSY: begin
        if (finish) begin
          state_d = lbc_pkg::ST_IDLE;
          ov_d    = 1'b1;
        end
      end
      default: begin
        state_d = lbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lbc_pkg::ST_IDLE;
      ov_q      <= 1'b0;
      blink_q   <= 1'b0;
      counted_q <= 1'b0;
      level_q   <= 1'b0;
      freq_q    <= '0;
      hp_q      <= lbc_pkg::HalfPeriodDefault;
      tl_q      <= '0;
      last_q    <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (finish) begin
        blink_q   <= blink_d;
        counted_q <= counted_d;
        level_q   <= level_d;
        freq_q    <= freq_d;
        hp_q      <= hp_d;
        tl_q      <= tl_d;
        last_q    <= last_d;
      end
    end
  end

  // Load the result only when the previous one has left
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= {4'd0, blinks_sum[16:1], freq_d, blink_d, level_d, dled, op};
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  // A new item starts both serial units
  a_units_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> cmp_busy && div_busy)
    else $error("serial units did not start on an input transfer");

  // Serial units run only while an item is held
  a_units_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmp_busy || div_busy) |-> state_q == lbc_pkg::ST_BUSY)
    else $error("serial unit running outside an item");

  // Counted mode and a held frequency only exist while blinking
  a_counted_blink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counted_q |-> blink_q)
    else $error("counted mode without blinking");

  a_freq_blink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (freq_q != '0) |-> blink_q)
    else $error("frequency held without blinking");

  // A finished item never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (!ov_q || m_axis_tready))
    else $error("result overwritten before transfer");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Action codes the block does not define; it must pass them through as no-ops
  localparam logic [2:0]  ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;
  localparam logic [15:0] DefaultHalfMs = 16'd500;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned MaxPrinted    = 40;
  localparam int unsigned IdleItems     = 1500;
  localparam int unsigned TotalItems    = 1650;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  led;
    logic [15:0] period;
    logic [15:0] hz;
    logic [15:0] count;
    logic [31:0] stamp;
  } blink_cmd_t;

  typedef struct {
    lbc_pkg::drive_op_e op;
    logic [7:0]  led;
    logic        level;
    logic        blinking;
    logic [15:0] freq;
    logic [15:0] left;
  } blink_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  // Tracked copy of the blink state
  logic        pr_blink;
  logic        pr_counted;
  logic        pr_level;
  logic [15:0] pr_freq;
  logic [15:0] pr_half;
  logic [15:0] pr_toggles;
  logic [31:0] pr_last;

  blink_result_t pending_results[$];
  logic [31:0]   now_ms;
  int unsigned   items_sent    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles  = 0;
  int unsigned   gap_pct       = 25;
  int unsigned   stall_pct     = 5;
  bit            idle_en       = 1'b1;

  led_blink_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Blink state predictor
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] half_ms_of_hz(input logic [15:0] hz);
    int unsigned q;
    if (hz == 16'd0) return DefaultHalfMs;
    q = 1000 / (2 * int'(hz));
    if (q == 0) q = 1;
    return q[15:0];
  endfunction

  function automatic void halt_blink();
    pr_blink   = 1'b0;
    pr_counted = 1'b0;
    pr_freq    = '0;
    pr_toggles = '0;
  endfunction

  function automatic blink_result_t predict_blink(input blink_cmd_t c);
    blink_result_t r;
    logic [31:0]   elapsed;
    r.op  = lbc_pkg::OP_NONE;
    r.led = '0;
    case (c.action)
      lbc_pkg::ACT_ON: begin
        halt_blink();
        pr_level = 1'b1;
        r.op     = lbc_pkg::OP_ON;
        r.led    = c.led;
      end
      lbc_pkg::ACT_OFF: begin
        halt_blink();
        pr_level = 1'b0;
        r.op     = lbc_pkg::OP_OFF;
        r.led    = c.led;
      end
      lbc_pkg::ACT_TOGGLE: begin
        halt_blink();
        pr_level = ~pr_level;
        r.op     = lbc_pkg::OP_TOGGLE;
        r.led    = c.led;
      end
      lbc_pkg::ACT_PERIOD: begin
        // Toggle budget is left alone here
        pr_blink   = 1'b1;
        pr_counted = 1'b0;
        pr_freq    = '0;
        pr_half    = (c.period == 16'd0) ? DefaultHalfMs : c.period;
        pr_last    = c.stamp;
      end
      lbc_pkg::ACT_HZ_CNT: begin
        pr_blink   = 1'b1;
        pr_counted = (c.count != 16'd0);
        pr_level   = 1'b0;
        pr_freq    = c.hz;
        pr_half    = half_ms_of_hz(c.hz);
        pr_toggles = (c.count > 16'd32767) ? 16'hFFFF : {c.count[14:0], 1'b0};
        pr_last    = c.stamp;
        r.op       = lbc_pkg::OP_OFF;
        r.led      = c.led;
      end
      lbc_pkg::ACT_TICK: begin
        elapsed = c.stamp - pr_last;
        if (pr_blink && elapsed >= 32'(pr_half)) begin
          pr_last  = c.stamp;
          pr_level = ~pr_level;
          r.op     = lbc_pkg::OP_TOGGLE;
          if (pr_counted) begin
            if (pr_toggles != 16'd0) pr_toggles = pr_toggles - 16'd1;
            // Last toggle of a counted run: stop and leave the LED dark
            if (pr_toggles == 16'd0) begin
              halt_blink();
              pr_level = 1'b0;
              r.op     = lbc_pkg::OP_OFF;
            end
          end
        end
      end
      default: ;
    endcase
    r.level    = pr_level;
    r.blinking = pr_blink;
    r.freq     = pr_freq;
    r.left     = 16'(({1'b0, pr_toggles} + 17'd1) >> 1);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic blink_cmd_t rand_cmd(input logic [2:0] act);
    blink_cmd_t c;
    c.action = act;
    c.led    = 8'($urandom);
    c.period = 16'($urandom);
    c.hz     = 16'($urandom);
    c.count  = 16'($urandom);
    c.stamp  = now_ms;
    return c;
  endfunction

  // Drive one command and predict its status once the block takes it
  task automatic send_item(input blink_cmd_t c);
    s_axis_tdata  <= {5'd0, c.stamp, c.count, c.hz, c.period, c.led, c.action};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_blink(c));
    items_sent++;
    if (idle_en && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_tick(input int unsigned step);
    blink_cmd_t c;
    now_ms = now_ms + step;
    c = rand_cmd(lbc_pkg::ACT_TICK);
    send_item(c);
  endtask

  // Tick spacing: mostly at or just past the half-period, sometimes short or huge
  function automatic int unsigned pick_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return int'(pr_half) + $urandom_range(0, 2);
      6, 7:             return $urandom_range(0, int'(pr_half));
      8:                return int'(pr_half) - 1;
      default:          return $urandom;
    endcase
  endfunction

  task automatic send_led_cmd(input logic [2:0] act, input logic [7:0] led);
    blink_cmd_t c;
    c = rand_cmd(act);
    c.led = led;
    send_item(c);
  endtask

  task automatic send_period(input logic [15:0] period);
    blink_cmd_t c;
    c = rand_cmd(lbc_pkg::ACT_PERIOD);
    c.period = period;
    send_item(c);
  endtask

  task automatic send_hz_count(input logic [15:0] hz, input logic [15:0] count);
    blink_cmd_t c;
    c = rand_cmd(lbc_pkg::ACT_HZ_CNT);
    c.hz    = hz;
    c.count = count;
    send_item(c);
  endtask

  // Counted run: start it, tick until it stops on its own or give up and stop it
  task automatic run_counted_seq();
    logic [15:0] hz;
    logic [15:0] count;
    int unsigned n;
    case ($urandom_range(0, 9))
      0:       hz = '0;
      1:       hz = 16'($urandom);
      2:       hz = 16'($urandom_range(400, 600));
      default: hz = 16'($urandom_range(1, 100));
    endcase
    case ($urandom_range(0, 9))
      0:       count = '0;
      1:       count = 16'($urandom);
      default: count = 16'($urandom_range(1, 5));
    endcase
    send_hz_count(hz, count);
    n = 0;
    while (pr_blink && n < 16) begin
      send_tick(pick_step());
      n++;
    end
    if (pr_blink)
      send_led_cmd(3'($urandom_range(lbc_pkg::ACT_ON, lbc_pkg::ACT_TOGGLE)),
                   8'($urandom));
  endtask

  task automatic run_period_seq();
    case ($urandom_range(0, 9))
      0:       send_period('0);
      1:       send_period(16'($urandom));
      default: send_period(16'($urandom_range(1, 20)));
    endcase
    repeat ($urandom_range(1, 8)) send_tick(pick_step());
    if ($urandom_range(0, 1) == 0)
      send_led_cmd(3'($urandom_range(lbc_pkg::ACT_ON, lbc_pkg::ACT_TOGGLE)),
                   8'($urandom));
  endtask

  // Any code at all, with a stamp near the running clock or anywhere
  task automatic send_noise();
    blink_cmd_t c;
    c = rand_cmd(3'($urandom_range(lbc_pkg::ACT_ON, ACT_UNUSED_HI)));
    if ($urandom_range(0, 1) == 0) c.stamp = $urandom;
    else c.stamp = now_ms + $urandom_range(0, 1000);
    now_ms = c.stamp;
    send_item(c);
  endtask

  task automatic run_random_seq();
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 50;
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: run_counted_seq();
      5, 6:          run_period_seq();
      default:       send_noise();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain LED commands, unknown codes, and a tick while nothing blinks
  task automatic test_drive_commands();
    now_ms = '0;
    send_led_cmd(lbc_pkg::ACT_ON, 8'hFF);
    send_led_cmd(lbc_pkg::ACT_OFF, 8'h00);
    send_led_cmd(lbc_pkg::ACT_TOGGLE, 8'hAA);
    send_led_cmd(lbc_pkg::ACT_TOGGLE, 8'h55);
    send_tick(1000);
    send_led_cmd(ACT_UNUSED_LO, 8'hFF);
    send_led_cmd(ACT_UNUSED_HI, 8'hFF);
  endtask

  // Half-period edges, hz and count extremes, counted end, timestamp wrap
  task automatic test_blink_timing();
    send_period('0);          // zero period falls back to the default
    send_tick(499);
    send_tick(1);
    send_period(16'hFFFF);
    send_tick(65534);
    send_tick(1);
    send_hz_count('0, '0);    // zero hz and zero count: default period, no limit
    send_tick(500);
    send_hz_count(16'hFFFF, 16'hFFFF);
    send_tick(1);
    send_hz_count(16'd500, 16'd32767);
    send_tick(1);
    send_hz_count(16'd501, 16'd32768);
    send_tick(0);             // no time passed: no toggle
    send_led_cmd(lbc_pkg::ACT_ON, 8'h0F);
    send_hz_count(16'd1, 16'd1);
    send_tick(500);
    send_tick(500);           // uses the last toggle
    now_ms = 32'hFFFF_FFFA;
    send_period(16'd10);
    send_tick(9);
    send_tick(1);             // elapsed crosses the wrap
  endtask

  task automatic test_random_traffic();
    while (items_sent < IdleItems) run_random_seq();
  endtask

  // Back-to-back transfers on both sides
  task automatic test_full_rate();
    idle_en = 1'b0;
    gap_pct = 0;
    while (items_sent < TotalItems) run_random_seq();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    pr_blink   = 1'b0;
    pr_counted = 1'b0;
    pr_level   = 1'b0;
    pr_freq    = '0;
    pr_half    = DefaultHalfMs;
    pr_toggles = '0;
    pr_last    = '0;
    now_ms     = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_drive_commands();
    test_blink_timing();
    test_random_traffic();
    test_full_rate();

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("** led_blink_controller: PASSED **");
    else $display("** led_blink_controller: FAILED **");
    $finish;
  end

  // Result side backpressure: random stall bursts, calm stretches in between
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 300 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 3;
          default: stall_pct = 10;
        endcase
      end
      if (!idle_en || $urandom_range(0, 99) >= stall_pct) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MaxPrinted)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $realtime, results_seen, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    blink_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata[31:0], 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.op)
          report_mismatch("drive_op", m_axis_tdata[1:0], want.op);
        if (m_axis_tdata[9:2] !== want.led)
          report_mismatch("drive_led", m_axis_tdata[9:2], want.led);
        if (m_axis_tdata[10] !== want.level)
          report_mismatch("led_level", m_axis_tdata[10], want.level);
        if (m_axis_tdata[11] !== want.blinking)
          report_mismatch("blinking", m_axis_tdata[11], want.blinking);
        if (m_axis_tdata[27:12] !== want.freq)
          report_mismatch("freq_status", m_axis_tdata[27:12], want.freq);
        if (m_axis_tdata[43:28] !== want.left)
          report_mismatch("blinks_left", m_axis_tdata[43:28], want.left);
      end
      results_seen++;
    end
  end

  // Stop a hung run: too long without a transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, WatchdogLimit);
      $display("** led_blink_controller: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/lbc_pkg.sv
rtl/core/lbc_elapsed.sv
rtl/core/lbc_div.sv
rtl/core/led_blink_controller.sv
sim/tb.sv
